[hw/rtl/srpm_pkg.sv]
// package for the scrollback ring pointer manager
// holds operation codes, register indexes and the controller/datapath structs
// no dependencies
package srpm_pkg;

	localparam int SRPM_RING_LINES_DEFAULT = 1024;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'b1;

	localparam logic [9:0] SCREEN_ROWS_RESET = 10'd24;
	localparam logic [9:0] SCREEN_COLS_RESET = 10'd80;

	localparam logic [2:0] FUNC_MOVE_HEAD  = 3'd0;
	localparam logic [2:0] FUNC_ADJ_SCROLL = 3'd1;
	localparam logic [2:0] FUNC_CLR_SCROLL = 3'd2;
	localparam logic [2:0] FUNC_MAP_WR     = 3'd3;
	localparam logic [2:0] FUNC_MAP_VIS    = 3'd4;

	localparam logic KIND_CLEAR  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic load;
		logic scroll_adj;
		logic scroll_clr;
		logic acc_bot;
		logic acc_map;
		logic acc_sub;
		logic step_up;
		logic step_down;
		logic emit_status;
	} srpm_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       delta_neg;
		logic       delta_zero;
		logic       acc_ge;
		logic       count_last;
		logic       head_eq_base;
	} srpm_stat_t;

endpackage

[hw/rtl/scrollback_ring_pointer_manager_core.sv]
// after accept, scroll ops, unknown codes and zero moves go from decode straight to the status state
// mappings pass through modular reduction first, upward moves reduce and then step the head up
// downward moves step the head down, ending early when the head stops at base
// one item at a time, the next is taken at the edge that ends the status word cycle
// results are strobed for one cycle, the receiver cannot stall
// reset: head = base = 1, scroll = 0, screen 24 rows by 80 columns
module scrollback_ring_pointer_manager_core import srpm_pkg::*; #(
	parameter int RING_LINES = SRPM_RING_LINES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           func,
	input  logic signed [6:0]    delta,
	input  logic [9:0]           row,
	input  logic [9:0]           col,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [9:0]           cfg_data,
	output logic                 result_valid,
	output logic                 kind,
	output logic [9:0]           line_index,
	output logic [9:0]           head_now,
	output logic [9:0]           base_now,
	output logic [9:0]           scroll_now,
	output logic [9:0]           history_count,
	output logic                 is_visible,
	output logic                 last
);

	srpm_cmd_t  cmd;
	srpm_stat_t stat;

	assign cfg_ready = 1'b1;

	srpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	srpm_datapath #(
		.RING_LINES (RING_LINES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.delta         (delta),
		.row           (row),
		.col           (col),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.kind          (kind),
		.line_index    (line_index),
		.head_now      (head_now),
		.base_now      (base_now),
		.scroll_now    (scroll_now),
		.history_count (history_count),
		.is_visible    (is_visible),
		.last          (last)
	);

endmodule

[hw/rtl/srpm_ctrl.sv]
// controller state machine of the scrollback ring pointer manager
// sequences decode, modular reduction, head steps and status emission
// depends on srpm_pkg
module srpm_ctrl import srpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  srpm_stat_t stat,
	output srpm_cmd_t  cmd,
	output logic       busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_REDUCE = 3'd2;
	localparam logic [2:0] ST_UP     = 3'd3;
	localparam logic [2:0] ST_DOWN   = 3'd4;
	localparam logic [2:0] ST_STATUS = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.func)
					FUNC_MOVE_HEAD: begin
						if (stat.delta_zero) begin
							state_d = ST_STATUS;
						end else if (stat.delta_neg) begin
							state_d = ST_DOWN;
						end else begin
							cmd.acc_bot = 1'b1;
							state_d     = ST_REDUCE;
						end
					end
					FUNC_ADJ_SCROLL: begin
						cmd.scroll_adj = 1'b1;
						state_d        = ST_STATUS;
					end
					FUNC_CLR_SCROLL: begin
						cmd.scroll_clr = 1'b1;
						state_d        = ST_STATUS;
					end
					FUNC_MAP_WR, FUNC_MAP_VIS: begin
						cmd.acc_map = 1'b1;
						state_d     = ST_REDUCE;
					end
					default: begin
						state_d = ST_STATUS;
					end
				endcase
			end
			ST_REDUCE: begin
				// one subtraction of the ring size per cycle
				if (stat.acc_ge) begin
					cmd.acc_sub = 1'b1;
				end else if (stat.func == FUNC_MOVE_HEAD) begin
					state_d = ST_UP;
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_UP: begin
				cmd.step_up = 1'b1;
				if (stat.count_last) begin
					state_d = ST_STATUS;
				end
			end
			ST_DOWN: begin
				if (stat.head_eq_base) begin
					state_d = ST_STATUS;
				end else begin
					cmd.step_down = 1'b1;
					if (stat.count_last) begin
						state_d = ST_STATUS;
					end
				end
			end
			ST_STATUS: begin
				cmd.emit_status = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hw/rtl/srpm_datapath.sv]
// datapath of the scrollback ring pointer manager
// pointer registers, reduction accumulator, step counter, config and result registers
// depends on srpm_pkg
module srpm_datapath import srpm_pkg::*; #(
	parameter int RING_LINES = SRPM_RING_LINES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srpm_cmd_t            cmd,
	output srpm_stat_t           stat,
	input  logic [2:0]           func,
	input  logic signed [6:0]    delta,
	input  logic [9:0]           row,
	input  logic [9:0]           col,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [9:0]           cfg_data,
	output logic                 result_valid,
	output logic                 kind,
	output logic [9:0]           line_index,
	output logic [9:0]           head_now,
	output logic [9:0]           base_now,
	output logic [9:0]           scroll_now,
	output logic [9:0]           history_count,
	output logic                 is_visible,
	output logic                 last
);

	localparam int PW = $clog2(RING_LINES);
	localparam int RW = ((PW > 10) ? PW : 10) + 2;
	localparam logic [RW-1:0] RL_R   = RW'(RING_LINES);
	localparam logic [PW-1:0] RL_MAX = PW'(RING_LINES - 1);

	logic [PW-1:0]     head_q, base_q, scroll_q;
	logic [RW-1:0]     acc_q;
	logic [6:0]        cnt_q;
	logic [2:0]        func_q;
	logic signed [6:0] delta_q;
	logic [9:0]        row_q, col_q;
	logic [9:0]        rows_q, cols_q;

	function automatic logic [PW-1:0] inc_wrap(input logic [PW-1:0] p);
		return (p == RL_MAX) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] dec_wrap(input logic [PW-1:0] p);
		return (p == '0) ? RL_MAX : p - PW'(1);
	endfunction

	function automatic logic [PW-1:0] hist_of(input logic [PW-1:0] h, input logic [PW-1:0] b);
		logic [RW-1:0] d;
		d = RW'(h) - RW'(b) + ((h < b) ? RL_R : '0);
		return d[PW-1:0];
	endfunction

	function automatic logic [9:0] lo10(input logic [PW-1:0] p);
		logic [RW-1:0] w;
		w = RW'(p);
		return w[9:0];
	endfunction

	logic [PW-1:0]        hist;
	logic [9:0]           crow;
	logic signed [RW-1:0] s_sum;
	logic [PW-1:0]        s_new;
	logic [PW-1:0]        head_up, bot_up, base_up;
	logic                 hit;
	logic                 vis;
	logic [6:0]           delta_mag;

	assign hist = hist_of(head_q, base_q);

	// row clamp to the screen, zero rows gives row 0
	assign crow = (rows_q == 10'd0) ? 10'd0 :
		((row_q > rows_q - 10'd1) ? rows_q - 10'd1 : row_q);

	assign s_sum = signed'(RW'(scroll_q)) + signed'({{(RW-7){delta_q[6]}}, delta_q});

	always_comb begin
		if (s_sum[RW-1]) begin
			s_new = '0;
		end else if (unsigned'(s_sum) > RW'(hist)) begin
			s_new = hist;
		end else begin
			s_new = s_sum[PW-1:0];
		end
	end

	// acc holds the bottom line below the screen during an upward move
	assign head_up = inc_wrap(head_q);
	assign bot_up  = inc_wrap(acc_q[PW-1:0]);
	assign hit     = (bot_up == base_q);
	assign base_up = hit ? inc_wrap(base_q) : base_q;

	// unsigned visibility test written as col < cols and row + scroll < rows
	assign vis = (col_q < cols_q) && ((RW'(row_q) + RW'(scroll_q)) < RW'(rows_q));

	assign delta_mag = delta[6] ? (~delta + 7'd1) : delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SCREEN_ROWS_RESET;
			cols_q <= SCREEN_COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_ROWS: rows_q <= cfg_data;
				CFG_SCREEN_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= PW'(1);
			base_q   <= PW'(1);
			scroll_q <= '0;
		end else begin
			if (cmd.scroll_adj) begin
				scroll_q <= s_new;
			end else if (cmd.scroll_clr) begin
				scroll_q <= '0;
			end
			if (cmd.step_up) begin
				head_q <= head_up;
				base_q <= base_up;
			end else if (cmd.step_down) begin
				head_q <= dec_wrap(head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			delta_q <= delta;
			row_q   <= row;
			col_q   <= col;
			cnt_q   <= delta_mag;
		end else if (cmd.step_up || cmd.step_down) begin
			cnt_q <= cnt_q - 7'd1;
		end
		if (cmd.acc_bot) begin
			acc_q <= RW'(head_q) + RW'(rows_q);
		end else if (cmd.acc_map) begin
			if (func_q == FUNC_MAP_VIS) begin
				acc_q <= RW'(head_q) + RL_R - RW'(scroll_q) + RW'(crow);
			end else begin
				acc_q <= RW'(head_q) + RW'(crow);
			end
		end else if (cmd.acc_sub) begin
			acc_q <= acc_q - RL_R;
		end else if (cmd.step_up) begin
			acc_q <= RW'(bot_up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (cmd.step_up && hit) || cmd.emit_status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_up) begin
			kind          <= KIND_CLEAR;
			line_index    <= lo10(bot_up);
			head_now      <= lo10(head_up);
			base_now      <= lo10(base_up);
			scroll_now    <= lo10(scroll_q);
			history_count <= lo10(hist_of(head_up, base_up));
			is_visible    <= 1'b0;
			last          <= 1'b0;
		end else if (cmd.emit_status) begin
			kind          <= KIND_STATUS;
			line_index    <= (func_q inside {FUNC_MAP_WR, FUNC_MAP_VIS}) ? acc_q[9:0] : 10'd0;
			head_now      <= lo10(head_q);
			base_now      <= lo10(base_q);
			scroll_now    <= lo10(scroll_q);
			history_count <= lo10(hist);
			is_visible    <= (func_q == FUNC_MAP_VIS) ? vis : 1'b0;
			last          <= 1'b1;
		end
	end

	always_comb begin
		stat.func         = func_q;
		stat.delta_neg    = delta_q[6];
		stat.delta_zero   = (delta_q == 7'sd0);
		stat.acc_ge       = (acc_q >= RL_R);
		stat.count_last   = (cnt_q == 7'd1);
		stat.head_eq_base = (head_q == base_q);
	end

endmodule

[hw/rtl/srpm_checker.sv]
// port-level checker for the scrollback ring pointer manager
// bound to scrollback_ring_pointer_manager_core, sees its ports only
module srpm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic kind,
	input logic is_visible,
	input logic last
);

	// an accepted command keeps the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted command");

	// a clear word never ends a command and never reports visibility
	a_clear_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !kind) |-> (!last && !is_visible))
		else $error("clear word with last or is_visible set");

	// the final word comes exactly as busy drops
	a_fell_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && last))
		else $error("busy dropped without a final word");

	// intermediate words only while the command is still in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("intermediate word while idle");

endmodule

bind scrollback_ring_pointer_manager_core srpm_checker u_srpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.kind         (kind),
	.is_visible   (is_visible),
	.last         (last)
);
